FILE: sv/rpd_pkg.sv
package rpd_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W = 11;
    localparam int VAL_W = 10;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int DIV_STEPS = 32;
    localparam int STEP_W = 5;
    localparam int GROUP = 32;

    localparam logic [CNT_W-1:0] PERM_SIZE_RESET = 11'd1024;
    localparam logic [CNT_W-1:0] DRAW_COUNT_RESET = 11'd1024;

    localparam logic REG_PERM_SIZE = 1'b0;
    localparam logic REG_DRAW_COUNT = 1'b1;

    typedef struct packed {
        logic              restart;
        logic [WORD_W-1:0] random_word;
    } in_t;

    typedef struct packed {
        logic [VAL_W-1:0] element;
        logic             last;
    } out_t;

    typedef struct packed {
        logic fill;
        logic shift;
    } pool_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_SEND
    } state_t;

endpackage

FILE: sv/rpd_cell.sv
module rpd_cell #(
    parameter int IDX_W = 10,
    parameter int INDEX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rpd_pkg::pool_ctrl_t         ctrl,
    input  logic [rpd_pkg::CNT_W-1:0]   pos,
    input  logic [rpd_pkg::CNT_W-1:0]   remaining,
    input  logic [rpd_pkg::VAL_W-1:0]   next_val,
    output logic [rpd_pkg::VAL_W-1:0]   val,
    output logic [rpd_pkg::VAL_W-1:0]   hit_val
);

    localparam int CW = ((IDX_W > rpd_pkg::CNT_W) ? IDX_W : rpd_pkg::CNT_W) + 1;
    localparam logic [CW-1:0] MY_IDX = CW'(INDEX);
    localparam logic [rpd_pkg::VAL_W-1:0] IDENT = rpd_pkg::VAL_W'(INDEX);

    logic [rpd_pkg::VAL_W-1:0] val_reg;
    logic [rpd_pkg::VAL_W-1:0] val_next;
    logic [CW-1:0]             pos_x;
    logic [CW-1:0]             rem_x;
    logic                      hit;
    logic                      move;

    assign pos_x = CW'(pos);
    assign rem_x = CW'(remaining);
    assign hit   = (MY_IDX == pos_x);
    assign move  = ctrl.shift && (MY_IDX >= pos_x) && ((MY_IDX + CW'(1)) < rem_x);

    always_comb
    begin
        if (ctrl.fill)
        begin
            val_next = IDENT;
        end
        else if (move)
        begin
            val_next = next_val;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= IDENT;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign val     = val_reg;
    assign hit_val = hit ? val_reg : '0;

endmodule

FILE: sv/rpd_pool.sv
module rpd_pool #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rpd_pkg::pool_ctrl_t         ctrl,
    input  logic [rpd_pkg::CNT_W-1:0]   pos,
    input  logic [rpd_pkg::CNT_W-1:0]   remaining,
    output logic [rpd_pkg::VAL_W-1:0]   value
);

    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NGROUP = (MAX_SIZE + rpd_pkg::GROUP - 1) / rpd_pkg::GROUP;
    localparam int NPAD = NGROUP * rpd_pkg::GROUP;

    logic [rpd_pkg::VAL_W-1:0] cell_val [MAX_SIZE+1];
    logic [rpd_pkg::VAL_W-1:0] hit_val  [NPAD];
    logic [rpd_pkg::VAL_W-1:0] group_reg  [NGROUP];
    logic [rpd_pkg::VAL_W-1:0] group_next [NGROUP];

    assign cell_val[MAX_SIZE] = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_SIZE; k++)
        begin : g_cell
            rpd_cell #(
                .IDX_W (IDX_W),
                .INDEX (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .pos       (pos),
                .remaining (remaining),
                .next_val  (cell_val[k+1]),
                .val       (cell_val[k]),
                .hit_val   (hit_val[k])
            );
        end
        for (k = MAX_SIZE; k < NPAD; k++)
        begin : g_pad
            assign hit_val[k] = '0;
        end
    endgenerate

    // The selected entry is gathered in groups at the same edge as the chain closes the gap.
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < rpd_pkg::GROUP; j++)
            begin
                group_next[g] = group_next[g] | hit_val[g*rpd_pkg::GROUP + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int g = 0; g < NGROUP; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb
    begin
        value = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            value = value | group_reg[g];
        end
    end

endmodule

FILE: sv/rpd_divider.sv
module rpd_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rpd_pkg::WORD_W-1:0]  dividend,
    input  logic [rpd_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [rpd_pkg::CNT_W-1:0]   remainder
);

    localparam logic [rpd_pkg::STEP_W-1:0] LAST_STEP = rpd_pkg::STEP_W'(rpd_pkg::DIV_STEPS - 1);

    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;
    logic [rpd_pkg::STEP_W-1:0]   step_reg;
    logic [rpd_pkg::STEP_W-1:0]   step_next;
    logic [rpd_pkg::WORD_W-1:0]   shift_reg;
    logic [rpd_pkg::WORD_W-1:0]   shift_next;
    logic [rpd_pkg::CNT_W-1:0]    divisor_reg;
    logic [rpd_pkg::CNT_W-1:0]    divisor_next;
    logic [rpd_pkg::CNT_W-1:0]    rem_reg;
    logic [rpd_pkg::CNT_W-1:0]    rem_next;
    logic [rpd_pkg::CNT_W:0]      trial;

    assign trial = {rem_reg, shift_reg[rpd_pkg::WORD_W-1]};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            shift_next   = dividend;
            divisor_next = divisor;
            rem_next     = '0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[rpd_pkg::WORD_W-2:0], 1'b0};
            step_next  = step_reg + 1'b1;
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = rpd_pkg::CNT_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = trial[rpd_pkg::CNT_W-1:0];
            end
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/random_permutation_drawer.sv
// An accepted request that draws an element passes through the bit-serial modulo unit, a step
// that hands over its remainder, a step that closes the gap in the cell chain and gathers
// the entry, and a step that loads the output register.
// One request is in flight at a time and the input reopens after the result is loaded, so a
// draw may wait on an output stall of an earlier result; an exhausted request ends without a draw.
// Reset fills the pool with the identity order, clears the drawn count and sets both registers to 1024.
module random_permutation_drawer #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rpd_pkg::DATA_W-1:0]   pwdata,
    output logic [rpd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  rpd_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output rpd_pkg::out_t                out_data
);

    localparam int MAX_W = $clog2(MAX_SIZE + 1);
    localparam int CMP_W = (MAX_W > rpd_pkg::CNT_W) ? MAX_W : rpd_pkg::CNT_W;

    rpd_pkg::state_t             state_reg;
    rpd_pkg::state_t             state_next;
    logic [rpd_pkg::CNT_W-1:0]   perm_size_reg;
    logic [rpd_pkg::CNT_W-1:0]   draw_count_reg;
    logic [rpd_pkg::CNT_W-1:0]   drawn_reg;
    logic [rpd_pkg::CNT_W-1:0]   drawn_next;
    logic [rpd_pkg::CNT_W-1:0]   remaining_reg;
    logic [rpd_pkg::CNT_W-1:0]   remaining_next;
    logic                        last_reg;
    logic                        last_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    rpd_pkg::out_t               out_data_reg;
    rpd_pkg::out_t               out_data_next;

    logic                        cfg_write;
    logic                        accept;
    logic                        take;
    logic                        out_free;
    logic [rpd_pkg::CNT_W-1:0]   size_eff;
    logic [rpd_pkg::CNT_W-1:0]   count_eff;
    logic [rpd_pkg::CNT_W-1:0]   drawn_eff;
    logic [CMP_W-1:0]            size_wide;
    logic                        div_done;
    logic [rpd_pkg::CNT_W-1:0]   div_rem;
    logic [rpd_pkg::VAL_W-1:0]   pool_value;
    rpd_pkg::pool_ctrl_t         pool_ctrl;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            rpd_pkg::REG_PERM_SIZE:  prdata = rpd_pkg::DATA_W'(perm_size_reg);
            rpd_pkg::REG_DRAW_COUNT: prdata = rpd_pkg::DATA_W'(draw_count_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_size_reg  <= rpd_pkg::PERM_SIZE_RESET;
            draw_count_reg <= rpd_pkg::DRAW_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == rpd_pkg::REG_PERM_SIZE)
            begin
                perm_size_reg <= pwdata[rpd_pkg::CNT_W-1:0];
            end
            else
            begin
                draw_count_reg <= pwdata[rpd_pkg::CNT_W-1:0];
            end
        end
    end

    assign size_wide = CMP_W'(perm_size_reg);

    always_comb
    begin
        if (perm_size_reg == '0)
        begin
            size_eff = rpd_pkg::CNT_W'(1);
        end
        else if (size_wide > CMP_W'(MAX_SIZE))
        begin
            size_eff = rpd_pkg::CNT_W'(MAX_SIZE);
        end
        else
        begin
            size_eff = perm_size_reg;
        end
        count_eff = (draw_count_reg > size_eff) ? size_eff : draw_count_reg;
    end

    assign in_stall  = (state_reg != rpd_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign drawn_eff = in_data.restart ? '0 : drawn_reg;
    assign take      = (drawn_eff < count_eff);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        drawn_next      = drawn_reg;
        remaining_next  = remaining_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        pool_ctrl.fill  = 1'b0;
        pool_ctrl.shift = 1'b0;
        case (state_reg)
            rpd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pool_ctrl.fill = in_data.restart;
                    drawn_next     = drawn_eff;
                    if (take)
                    begin
                        drawn_next     = drawn_eff + 1'b1;
                        remaining_next = size_eff - drawn_eff;
                        last_next      = ((drawn_eff + 1'b1) == count_eff);
                        state_next     = rpd_pkg::ST_DIVIDE;
                    end
                end
            end
            rpd_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = rpd_pkg::ST_READ;
                end
            end
            rpd_pkg::ST_READ:
            begin
                pool_ctrl.shift = 1'b1;
                state_next      = rpd_pkg::ST_SEND;
            end
            rpd_pkg::ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.element = pool_value;
                    out_data_next.last    = last_reg;
                    state_next            = rpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpd_pkg::ST_IDLE;
            drawn_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drawn_reg     <= drawn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
        last_reg      <= last_next;
        out_data_reg  <= out_data_next;
    end

    rpd_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && take),
        .dividend  (in_data.random_word),
        .divisor   (remaining_next),
        .done      (div_done),
        .remainder (div_rem)
    );

    rpd_pool #(
        .MAX_SIZE (MAX_SIZE)
    ) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (pool_ctrl),
        .pos       (div_rem),
        .remaining (remaining_reg),
        .value     (pool_value)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == rpd_pkg::ST_DIVIDE))
        else $error("Modulo unit finished outside the divide phase.");

    a_remaining_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpd_pkg::ST_DIVIDE) |-> (remaining_reg != '0))
        else $error("Draw started with an empty pool.");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpd_pkg::ST_READ) |-> (div_rem < remaining_reg))
        else $error("Selected position lies beyond the remaining entries.");

    a_result_from_send: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == rpd_pkg::ST_SEND))
        else $error("Result appeared without a completed draw.");

endmodule
